>>> sv/serial_angle_frame_parser_defines.svh
// Assertion macros shared by the serial angle frame parser RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SERIAL_ANGLE_FRAME_PARSER_DEFINES_SVH
`define SERIAL_ANGLE_FRAME_PARSER_DEFINES_SVH

// Clocked check with a caller-supplied message, disabled during reset
`define SAF_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check with a generic message
`define SAF_ASSERT(lbl, clk, rst, prop) \
   `SAF_ASSERT_MSG(lbl, clk, rst, prop, "serial angle frame parser check failed")

`endif

>>> sv/saf_pkg.sv
// Shared types and constants for the serial angle frame parser.
// No dependencies; used by saf_frame_tracker, saf_point_counter and the top level.
package saf_pkg;

   // Stream marks
   localparam logic [7:0] SYNC_FIRST  = 8'h53;  // 'S'
   localparam logic [7:0] SYNC_SECOND = 8'h54;  // 'T'
   localparam logic [7:0] FRAME_MARK  = 8'h42;  // 'B'

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 4;
   localparam int WORD_W  = 32;
   localparam int BATCH_W = 16;

   // Angle occupies the first payload bytes, little-endian
   localparam int ANGLE_BYTES = 4;

   localparam logic [BATCH_W-1:0] BATCH_SIZE_RESET = 16'd200;

   // Frame tracker -> top: a finished frame with no alarm
   typedef struct packed {
      logic              point;
      logic [WORD_W-1:0] angle;
   } frame_evt_type;

   // Point counter -> top: index and batch status of the current point
   typedef struct packed {
      logic [WORD_W-1:0] index;
      logic              batch_ready;
      logic [WORD_W-1:0] batch_start;
   } point_info_type;

endpackage

>>> sv/saf_frame_tracker.sv
// Frame tracker: sync hunt, 'B' search and payload assembly, one byte per step.
// Depends on saf_pkg and serial_angle_frame_parser_defines.svh.
`include "serial_angle_frame_parser_defines.svh"

module saf_frame_tracker #(
   parameter int PAYLOAD_BYTES = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [saf_pkg::BYTE_W-1:0]   rx_byte,
   output saf_pkg::frame_evt_type       evt
);

   typedef enum logic [1:0] {
      PH_SYNC_EVEN,
      PH_SYNC_ODD,
      PH_SEEK,
      PH_PAYLOAD
   } phase_type;

   localparam logic [saf_pkg::POS_W-1:0] LAST_POS = saf_pkg::POS_W'(PAYLOAD_BYTES - 1);

   phase_type                     phase_ff, phase_in;
   logic [saf_pkg::BYTE_W-1:0]    sync_byte_ff, sync_byte_in;
   logic [saf_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [saf_pkg::WORD_W-1:0]    acc_ff, acc_in;
   logic [saf_pkg::WORD_W-1:0]    acc_merged;

   // Merge the current byte into its angle lane
   always_comb begin
      acc_merged = acc_ff;
      for (int k = 0; k < saf_pkg::ANGLE_BYTES; k++) begin
         if (pos_ff == saf_pkg::POS_W'(k)) begin
            acc_merged[saf_pkg::BYTE_W*k +: saf_pkg::BYTE_W] =
               acc_ff[saf_pkg::BYTE_W*k +: saf_pkg::BYTE_W] | rx_byte;
         end
      end
   end

   // Next state and frame event
   always_comb begin
      phase_in     = phase_ff;
      sync_byte_in = sync_byte_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      evt.point    = 1'b0;
      evt.angle    = acc_merged;
      unique case (phase_ff)
         PH_SYNC_EVEN: begin
            sync_byte_in = rx_byte;
            phase_in     = PH_SYNC_ODD;
         end
         PH_SYNC_ODD: begin
            if (sync_byte_ff == saf_pkg::SYNC_FIRST && rx_byte == saf_pkg::SYNC_SECOND) begin
               phase_in = PH_SEEK;
            end else begin
               phase_in = PH_SYNC_EVEN;
            end
         end
         PH_SEEK: begin
            if (rx_byte == saf_pkg::FRAME_MARK) begin
               phase_in = PH_PAYLOAD;
               pos_in   = '0;
               acc_in   = '0;
            end
         end
         PH_PAYLOAD: begin
            acc_in = acc_merged;
            if (pos_ff == LAST_POS) begin
               // alarm byte: zero means a good point
               phase_in  = PH_SEEK;
               pos_in    = '0;
               evt.point = (rx_byte == '0);
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
            phase_in = PH_SYNC_EVEN;
         end
      endcase
   end

   // State registers, advanced once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC_EVEN;
         sync_byte_ff <= '0;
         pos_ff       <= '0;
         acc_ff       <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sync_byte_ff <= sync_byte_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
      end
   end

   // Payload position never runs past the frame
   `SAF_ASSERT(a_pos_in_frame, clock, reset, phase_ff == PH_PAYLOAD |-> pos_ff <= LAST_POS)

endmodule

>>> sv/saf_point_counter.sv
// Point counter: running point index and batch tracking.
// Depends on saf_pkg and serial_angle_frame_parser_defines.svh.
`include "serial_angle_frame_parser_defines.svh"

module saf_point_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [saf_pkg::BATCH_W-1:0]   batch_size,
   output saf_pkg::point_info_type       info
);

   logic [saf_pkg::WORD_W-1:0]  point_cnt_ff, point_cnt_in;
   logic [saf_pkg::BATCH_W-1:0] batch_cnt_ff, batch_cnt_in;
   logic [saf_pkg::BATCH_W-1:0] size_eff;
   logic [saf_pkg::BATCH_W-1:0] batch_cnt_inc;
   logic                        batch_hit;

   // A zero batch size acts as one
   always_comb begin
      size_eff      = (batch_size == '0) ? saf_pkg::BATCH_W'(1) : batch_size;
      batch_cnt_inc = batch_cnt_ff + 1'b1;
      batch_hit     = (batch_cnt_inc >= size_eff);

      info.index       = point_cnt_ff;
      info.batch_ready = batch_hit;
      info.batch_start = batch_hit ?
         (point_cnt_ff + 1'b1 - {{(saf_pkg::WORD_W-saf_pkg::BATCH_W){1'b0}}, batch_cnt_inc})
         : '0;

      point_cnt_in = point_cnt_ff + 1'b1;
      batch_cnt_in = batch_hit ? '0 : batch_cnt_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_cnt_ff <= '0;
         batch_cnt_ff <= '0;
      end else if (step) begin
         point_cnt_ff <= point_cnt_in;
         batch_cnt_ff <= batch_cnt_in;
      end
   end

   // Each emitted point bumps the index by exactly one
   `SAF_ASSERT(a_index_bumps, clock, reset, step |=> point_cnt_ff == $past(point_cnt_ff) + 1'b1)
   // A completed batch restarts the batch count
   `SAF_ASSERT(a_batch_clears, clock, reset, step && batch_hit |=> batch_cnt_ff == '0)

endmodule

>>> sv/serial_angle_frame_parser.sv
// Serial angle frame parser: takes one received byte per word and emits one word per
// good frame (point index, angle, batch status). The block sustains one byte per clock
// cycle while the input is not stalled; a byte is registered on entry, parsed by the frame
// tracker from that register and its point, if any, lands in the result register, from
// which it is presented. Bytes that give no point keep flowing while a result is stalled;
// only a second point behind a stalled result holds the input. batch_size is written
// through the csr port, which is always ready; write it only while the parser is idle.
// Depends on saf_pkg, saf_frame_tracker, saf_point_counter and the defines header.
`include "serial_angle_frame_parser_defines.svh"

module serial_angle_frame_parser #(
   parameter int PAYLOAD_BYTES = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [saf_pkg::BYTE_W-1:0]    req_rx_byte,
   // point output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [saf_pkg::WORD_W-1:0]    rsp_point_index,
   output logic [saf_pkg::WORD_W-1:0]    rsp_angle,
   output logic                          rsp_batch_ready,
   output logic [saf_pkg::WORD_W-1:0]    rsp_batch_start,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [saf_pkg::BATCH_W-1:0]   csr_batch_size
);

   logic                          in_valid_ff, in_valid_in;
   logic [saf_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;
   logic                          out_valid_ff, out_valid_in;
   logic [saf_pkg::WORD_W-1:0]    out_index_ff, out_index_in;
   logic [saf_pkg::WORD_W-1:0]    out_angle_ff, out_angle_in;
   logic                          out_ready_ff, out_ready_in;
   logic [saf_pkg::WORD_W-1:0]    out_start_ff, out_start_in;
   logic [saf_pkg::BATCH_W-1:0]   batch_size_ff;

   saf_pkg::frame_evt_type        evt;
   saf_pkg::point_info_type       info;
   logic                          out_free;
   logic                          advance;
   logic                          emit;

   saf_frame_tracker #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .evt     (evt)
   );

   saf_point_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .step       (emit),
      .batch_size (batch_size_ff),
      .info       (info)
   );

   // Flow control: a byte moves on unless it makes a point and the result slot is held
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!evt.point || out_free);
      emit      = advance && evt.point;
      req_stall = in_valid_ff && !advance;
      csr_ready = 1'b1;
   end

   // Input register next value
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register next value
   always_comb begin
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_angle_in = out_angle_ff;
      out_ready_in = out_ready_ff;
      out_start_in = out_start_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_index_in = info.index;
         out_angle_in = evt.angle;
         out_ready_in = info.batch_ready;
         out_start_in = info.batch_start;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         batch_size_ff <= saf_pkg::BATCH_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            batch_size_ff <= csr_batch_size;
         end
      end
      in_byte_ff   <= in_byte_in;
      out_index_ff <= out_index_in;
      out_angle_ff <= out_angle_in;
      out_ready_ff <= out_ready_in;
      out_start_ff <= out_start_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_index = out_index_ff;
   assign rsp_angle       = out_angle_ff;
   assign rsp_batch_ready = out_ready_ff;
   assign rsp_batch_start = out_start_ff;

   // Input only backs up behind a pending point that cannot leave
   `SAF_ASSERT(a_stall_cause, clock, reset, req_stall |-> in_valid_ff && evt.point && out_valid_ff && rsp_stall)

endmodule
